// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the power-state sync presser core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define PSSP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define PSSP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/pssp_pkg.sv =====
// ----------------------------------------------------------------------------
// pssp_pkg
// Types, register map and helpers for the power-state sync presser.
// ----------------------------------------------------------------------------
package pssp_pkg;

    localparam int TIMER_W = 16;
    localparam int RUN_W   = 8;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;

    localparam logic [TIMER_W-1:0] RESET_CHECK_INTERVAL  = 16'd250;
    localparam logic [TIMER_W-1:0] RESET_PRESS_LENGTH    = 16'd1000;
    localparam logic [TIMER_W-1:0] RESET_COOLDOWN_LENGTH = 16'd5000;
    localparam logic [RUN_W-1:0]   RESET_MISMATCH_NEEDED = 8'd2;
    localparam logic [RUN_W-1:0]   RUN_LIMIT             = 8'hFF;

    typedef enum logic [IDX_W-1:0] {
        REG_CHECK_INTERVAL  = 2'd0,
        REG_PRESS_LENGTH    = 2'd1,
        REG_COOLDOWN_LENGTH = 2'd2,
        REG_MISMATCH_NEEDED = 2'd3
    } pssp_reg_t;

    typedef struct packed {
        logic update_desired;
        logic desired_on;
        logic led_line_level;
    } pssp_in_t;

    typedef struct packed {
        logic             button_drive;
        logic             press_started;
        logic             press_ended;
        logic             led_on;
        logic [RUN_W-1:0] mismatch_count;
    } pssp_out_t;

    typedef struct packed {
        logic [TIMER_W-1:0] check_interval;
        logic [TIMER_W-1:0] press_length;
        logic [TIMER_W-1:0] cooldown_length;
        logic [RUN_W-1:0]   mismatch_needed;
    } pssp_cfg_t;

    typedef struct packed {
        logic               desired_known;
        logic               desired_state;
        logic               press_active;
        logic [TIMER_W-1:0] press_timer;
        logic [TIMER_W-1:0] check_timer;
        logic [TIMER_W-1:0] cooldown_timer;
        logic [RUN_W-1:0]   mismatch_run;
    } pssp_state_t;

    localparam pssp_state_t STATE_RESET = '{
        desired_known:  1'b0,
        desired_state:  1'b0,
        press_active:   1'b0,
        press_timer:    '0,
        check_timer:    '0,
        cooldown_timer: '0,
        mismatch_run:   '0
    };

    // Decrement, hold at zero.
    function automatic logic [TIMER_W-1:0] count_down(input logic [TIMER_W-1:0] t);
        count_down = (t == '0) ? '0 : t - 1'b1;
    endfunction

endpackage

// ===== src/pssp_cfg.sv =====
// ----------------------------------------------------------------------------
// pssp_cfg
// Configuration register file: four write-only registers with reset values.
// ----------------------------------------------------------------------------
module pssp_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [pssp_pkg::IDX_W-1:0]     cfg_index,
    input  logic [pssp_pkg::CFG_W-1:0]     cfg_wdata,
    output pssp_pkg::pssp_cfg_t            cfg
);
    import pssp_pkg::*;

    pssp_cfg_t cfg_reg;
    pssp_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (pssp_reg_t'(cfg_index))
                REG_CHECK_INTERVAL:  cfg_next.check_interval  = cfg_wdata;
                REG_PRESS_LENGTH:    cfg_next.press_length    = cfg_wdata;
                REG_COOLDOWN_LENGTH: cfg_next.cooldown_length = cfg_wdata;
                REG_MISMATCH_NEEDED: cfg_next.mismatch_needed = cfg_wdata[RUN_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.check_interval  <= RESET_CHECK_INTERVAL;
            cfg_reg.press_length    <= RESET_PRESS_LENGTH;
            cfg_reg.cooldown_length <= RESET_COOLDOWN_LENGTH;
            cfg_reg.mismatch_needed <= RESET_MISMATCH_NEEDED;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/pssp_step.sv =====
// ----------------------------------------------------------------------------
// pssp_step
// One tick of the presser: timer countdown, LED check, press start and end.
// ----------------------------------------------------------------------------
module pssp_step (
    input  pssp_pkg::pssp_cfg_t   cfg,
    input  pssp_pkg::pssp_state_t cur,
    input  pssp_pkg::pssp_in_t    word_in,
    output pssp_pkg::pssp_state_t nxt,
    output pssp_pkg::pssp_out_t   word_out
);
    import pssp_pkg::*;

    logic             led_on;
    logic             started;
    logic             ended;
    logic [RUN_W-1:0] run_inc;

    assign led_on  = ~word_in.led_line_level;
    assign run_inc = (cur.mismatch_run != RUN_LIMIT) ? cur.mismatch_run + 1'b1
                                                      : cur.mismatch_run;

    always_comb begin
        nxt                = cur;
        started            = 1'b0;
        ended              = 1'b0;
        nxt.press_timer    = count_down(cur.press_timer);
        nxt.check_timer    = count_down(cur.check_timer);
        nxt.cooldown_timer = count_down(cur.cooldown_timer);

        // Take a new desired state before this tick's check.
        if (word_in.update_desired) begin
            nxt.desired_state = word_in.desired_on;
            nxt.desired_known = 1'b1;
        end

        if (nxt.desired_known) begin
            if (cur.press_active) begin
                if (nxt.press_timer == '0) begin
                    nxt.press_active   = 1'b0;
                    ended              = 1'b1;
                    nxt.check_timer    = cfg.check_interval;
                    nxt.cooldown_timer = cfg.cooldown_length;
                    nxt.mismatch_run   = '0;
                end
            end else if (nxt.check_timer == '0) begin
                nxt.check_timer = cfg.check_interval;
                if (nxt.desired_state == led_on || nxt.cooldown_timer != '0) begin
                    nxt.mismatch_run = '0;
                end else if (run_inc >= cfg.mismatch_needed) begin
                    nxt.mismatch_run = '0;
                    nxt.press_active = 1'b1;
                    nxt.press_timer  = cfg.press_length;
                    started          = 1'b1;
                end else begin
                    nxt.mismatch_run = run_inc;
                end
            end
        end
    end

    assign word_out.button_drive   = nxt.press_active;
    assign word_out.press_started  = started;
    assign word_out.press_ended    = ended;
    assign word_out.led_on         = led_on;
    assign word_out.mismatch_count = nxt.mismatch_run;

endmodule

// ===== src/power_state_sync_presser_core.sv =====
// A word accepted on s_ moves from the input register to the result register and onto m_.
// Throughput: one word per cycle while m_ready is high; state updates in one pass of pssp_step.
// The input register takes a new word whenever it is empty or its word moves
// into the result register in the same cycle.
// Reset (aresetn low, synchronous): pipeline empty, tick state cleared,
// configuration registers back to 250 / 1000 / 5000 / 2.
// ----------------------------------------------------------------------------
// power_state_sync_presser_core
// Top level: input register, tick update, result register and config port.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module power_state_sync_presser_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  pssp_pkg::pssp_in_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output pssp_pkg::pssp_out_t        m_data,
    input  logic                       cfg_we,
    input  logic [pssp_pkg::IDX_W-1:0] cfg_index,
    input  logic [pssp_pkg::CFG_W-1:0] cfg_wdata
);
    import pssp_pkg::*;

    pssp_cfg_t   cfg;
    logic        in_valid_reg;
    pssp_in_t    in_data_reg;
    logic        out_valid_reg;
    pssp_out_t   out_data_reg;
    pssp_state_t state_reg;
    pssp_state_t state_next;
    pssp_out_t   result;
    logic        advance;

    pssp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pssp_step u_step (
        .cfg      (cfg),
        .cur      (state_reg),
        .word_in  (in_data_reg),
        .nxt      (state_next),
        .word_out (result)
    );

    // Move the held word into the result register when it is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `PSSP_ASSERT(a_start_drives, aclk, aresetn, (m_valid && m_data.press_started) |-> m_data.button_drive, "press start without button drive")
    `PSSP_ASSERT(a_end_releases, aclk, aresetn, (m_valid && m_data.press_ended) |-> !m_data.button_drive, "press end with button still driven")
    `PSSP_ASSERT(a_idle_quiet, aclk, aresetn, !state_reg.desired_known |-> (!state_reg.press_active && state_reg.mismatch_run == '0), "activity before a desired state")
    `PSSP_ASSERT(a_state_only_on_advance, aclk, aresetn, !$past(advance) |-> $stable(state_reg), "tick state changed without a word")

endmodule

// ===== verif/power_state_sync_presser_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// power_state_sync_presser_core_tb
// Self-checking bench for the power-state sync presser. A queue-fed driver
// sends tick words and a monitor checks every result word against a tick
// predictor kept in the bench. The run covers directed ticks at the default, zero
// and small settings, random phases with small timer settings, one phase with
// a long unbroken mismatch run, and a last phase at the largest timer settings.
// ----------------------------------------------------------------------------
module power_state_sync_presser_core_tb;
    import pssp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          IDLE_PCT    = 23;
    localparam int          PRINT_LIMIT = 200;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    pssp_in_t            s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    pssp_out_t           m_data;
    logic                cfg_we    = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;

    pssp_in_t            pending_ticks[$];
    pssp_out_t           expected_ticks[$];
    int                  fail_count  = 0;
    int                  ticks_seen  = 0;
    int unsigned         cycle_count = 0;
    bit                  steady      = 1'b0;
    bit                  gen_level   = 1'b1;

    // predictor settings and tick state
    logic [TIMER_W-1:0]  set_check;
    logic [TIMER_W-1:0]  set_press;
    logic [TIMER_W-1:0]  set_cool;
    logic [RUN_W-1:0]    set_need;
    logic                known;
    logic                want_on;
    logic                pressing;
    logic [TIMER_W-1:0]  press_left;
    logic [TIMER_W-1:0]  check_left;
    logic [TIMER_W-1:0]  cool_left;
    logic [RUN_W-1:0]    miss_run;

    power_state_sync_presser_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic pssp_out_t presser_tick(pssp_in_t w);
        pssp_out_t r;
        r = '0;
        r.led_on = ~w.led_line_level;
        // all timers advance first, holding at zero
        if (press_left != '0) press_left--;
        if (check_left != '0) check_left--;
        if (cool_left != '0) cool_left--;
        if (w.update_desired) begin
            want_on = w.desired_on;
            known   = 1'b1;
        end
        if (known) begin
            if (pressing) begin
                if (press_left == '0) begin
                    pressing      = 1'b0;
                    r.press_ended = 1'b1;
                    check_left    = set_check;
                    cool_left     = set_cool;
                    miss_run      = '0;
                end
            end else if (check_left == '0) begin
                check_left = set_check;
                if (want_on == r.led_on || cool_left != '0) begin
                    miss_run = '0;
                end else begin
                    if (miss_run != RUN_LIMIT) miss_run++;
                    if (miss_run >= set_need) begin
                        miss_run        = '0;
                        pressing        = 1'b1;
                        press_left      = set_press;
                        r.press_started = 1'b1;
                    end
                end
            end
        end
        r.button_drive   = pressing;
        r.mismatch_count = miss_run;
        return r;
    endfunction

    task automatic report_diff(string what, int got, int want);
        if (fail_count < PRINT_LIMIT)
            $display("ERROR: result word %0d, %s: got %0d, expected %0d",
                     ticks_seen, what, got, want);
        fail_count++;
    endtask

    task automatic write_setting(pssp_reg_t idx, logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_CHECK_INTERVAL:  set_check = val;
            REG_PRESS_LENGTH:    set_press = val;
            REG_COOLDOWN_LENGTH: set_cool  = val;
            REG_MISMATCH_NEEDED: set_need  = val[RUN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [TIMER_W-1:0] chk, logic [TIMER_W-1:0] prs,
                                  logic [TIMER_W-1:0] cool, logic [RUN_W-1:0] need);
        write_setting(REG_CHECK_INTERVAL, chk);
        write_setting(REG_PRESS_LENGTH, prs);
        write_setting(REG_COOLDOWN_LENGTH, cool);
        write_setting(REG_MISMATCH_NEEDED, {{(CFG_W-RUN_W){1'b0}}, need});
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic queue_tick(bit upd, bit want, bit level);
        pssp_in_t w;
        w.update_desired = upd;
        w.desired_on     = want;
        w.led_line_level = level;
        pending_ticks.push_back(w);
    endtask

    // LED level wanders with occasional flips; desired state changes now and then
    task automatic queue_random_run(int count, int upd_pct, int flip_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < flip_pct) gen_level = ~gen_level;
            queue_tick($urandom_range(99) < upd_pct, 1'($urandom_range(1)), gen_level);
        end
    endtask

    task automatic wait_drained();
        while (pending_ticks.size() != 0 || s_valid || expected_ticks.size() != 0)
            @(posedge aclk);
        // let the two pipeline stages settle before touching settings
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    // driver: predict each word as it is taken, then offer the next one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) expected_ticks.push_back(presser_tick(s_data));
            if (!s_valid || s_ready) begin
                if (pending_ticks.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    s_data  <= pending_ticks.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result word against the oldest prediction
    always @(posedge aclk) begin
        pssp_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            if (m_valid && m_ready) begin
                if (expected_ticks.size() == 0) begin
                    report_diff("word with no tick pending", 1, 0);
                end else begin
                    want = expected_ticks.pop_front();
                    if (m_data.button_drive !== want.button_drive)
                        report_diff("button_drive", int'(m_data.button_drive),
                                    int'(want.button_drive));
                    if (m_data.press_started !== want.press_started)
                        report_diff("press_started", int'(m_data.press_started),
                                    int'(want.press_started));
                    if (m_data.press_ended !== want.press_ended)
                        report_diff("press_ended", int'(m_data.press_ended),
                                    int'(want.press_ended));
                    if (m_data.led_on !== want.led_on)
                        report_diff("led_on", int'(m_data.led_on), int'(want.led_on));
                    if (m_data.mismatch_count !== want.mismatch_count)
                        report_diff("mismatch_count", int'(m_data.mismatch_count),
                                    int'(want.mismatch_count));
                end
                ticks_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int upd_pct;
        int flip_pct;

        set_check  = RESET_CHECK_INTERVAL;
        set_press  = RESET_PRESS_LENGTH;
        set_cool   = RESET_COOLDOWN_LENGTH;
        set_need   = RESET_MISMATCH_NEEDED;
        known      = 1'b0;
        want_on    = 1'b0;
        pressing   = 1'b0;
        press_left = '0;
        check_left = '0;
        cool_left  = '0;
        miss_run   = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings, no desired state yet: no checks or presses, timers stay at zero
        queue_tick(1'b0, 1'b0, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b1);
        queue_tick(1'b0, 1'b1, 1'b0);
        wait_drained();

        // zero settings: check every tick, one-tick presses, first mismatch presses
        apply_settings('0, '0, '0, '0);
        queue_tick(1'b1, 1'b0, 1'b1);
        queue_tick(1'b0, 1'b0, 1'b0);
        queue_tick(1'b0, 1'b0, 1'b0);
        queue_tick(1'b0, 1'b0, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b0);
        queue_tick(1'b1, 1'b1, 1'b0);
        queue_tick(1'b1, 1'b1, 1'b1);
        queue_tick(1'b0, 1'b0, 1'b1);
        wait_drained();

        // short press followed by cooldown that swallows mismatches
        apply_settings(16'd1, 16'd2, 16'd3, 8'd1);
        queue_tick(1'b1, 1'b0, 1'b0);
        for (int i = 0; i < 6; i++) queue_tick(1'b0, 1'b1, 1'b0);
        queue_tick(1'b0, 1'b0, 1'b1);
        queue_tick(1'b0, 1'b0, 1'b0);
        queue_tick(1'b0, 1'b1, 1'b0);
        wait_drained();

        // random phases with small timer settings
        for (int p = 0; p < 9; p++) begin
            apply_settings(TIMER_W'($urandom_range(0, 6)), TIMER_W'($urandom_range(0, 12)),
                           TIMER_W'($urandom_range(0, 20)), RUN_W'($urandom_range(0, 4)));
            steady   = (p == 4);
            upd_pct  = $urandom_range(1, 6);
            flip_pct = $urandom_range(2, 25);
            if (p == 0) queue_tick(1'b1, 1'($urandom_range(1)), gen_level);
            queue_random_run(150, upd_pct, flip_pct);
            wait_drained();
            steady = 1'b0;
        end

        // unbroken mismatch run long enough to need the largest count
        apply_settings('0, 16'd2, '0, RUN_LIMIT);
        queue_tick(1'b1, 1'b1, 1'b1);
        for (int i = 0; i < 320; i++) queue_tick(1'b0, 1'($urandom_range(1)), 1'b1);
        wait_drained();

        // largest timer settings: first mismatch starts a press that outlasts the run
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd1);
        queue_tick(1'b1, 1'b1, 1'b1);
        for (int i = 0; i < 120; i++)
            queue_tick($urandom_range(99) < 5, 1'($urandom_range(1)),
                       1'($urandom_range(1)));
        wait_drained();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
